// File: hdl/sri_pkg.sv
// Shared types, command codes and constants of the servo register interface.
package sri_pkg;

  localparam int unsigned CMD_W      = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam logic [ADDR_W-1:0] ADDR_RESET    = 7'd19;
  localparam logic [WORD_W-1:0] UPPER_RESET   = 16'hFFFF;
  localparam logic [BYTE_W-1:0] CEILING_RESET = 8'hFF;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADDR       = 8'd0;
  localparam logic [CMD_W-1:0] CMD_POS_SCALED = 8'd1;
  localparam logic [CMD_W-1:0] CMD_TGT_SCALED = 8'd2;
  localparam logic [CMD_W-1:0] CMD_CURRENT    = 8'd3;
  localparam logic [CMD_W-1:0] CMD_CEILING    = 8'd4;
  localparam logic [CMD_W-1:0] CMD_LOWER      = 8'd5;
  localparam logic [CMD_W-1:0] CMD_UPPER      = 8'd6;
  localparam logic [CMD_W-1:0] CMD_POSITION   = 8'd7;
  localparam logic [CMD_W-1:0] CMD_TARGET     = 8'd8;
  localparam logic [CMD_W-1:0] CMD_DRIVE      = 8'd10;

  // Request kinds carried in tuser
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Shape of the answer to a read of the stored command
  typedef enum logic [1:0] {
    ANS_NONE,
    ANS_BYTE,
    ANS_SCALE,
    ANS_PAIR
  } sri_ans_t;

  // Controller to datapath
  typedef struct packed {
    logic write_en;   // apply a write request
    logic capture;    // latch live fields of a read request
    logic prep_diff;  // form the offset and divisor
    logic prep_num;   // form the dividend and load the divider
    logic div_step;   // one restoring division step
    logic load;       // load the output register
    logic hi_byte;    // select the high byte of a word answer
    logic last;       // final byte of the answer
  } sri_cmd_t;

  // Datapath to controller
  typedef struct packed {
    sri_ans_t ans;      // answer shape of the stored command
    logic     out_free; // output register can take a byte this cycle
  } sri_stat_t;

endpackage

// File: hdl/servo_register_interface.sv
// Top level of the servo register interface: controller, datapath and checks.
// Timing: a read is captured in the idle state; a direct answer goes from the
// output state into the output register, a scaled answer first passes S_PREP0,
// S_PREP1 and 24 serial divider steps. Each load waits for output register room.
// Throughput: one request per cycle for writes, else once the last byte is loaded.
// Reset (rst_n low, synchronous) restores the address to 19, the limits, setpoint
// and maximum current to their defaults, and empties the output register.
module servo_register_interface (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata, from bit 0 up: command[7:0], data_low[15:8], data_high[23:16],
  // position[39:24], motor_current[47:40], drive_output[63:48]
  input  logic [63:0] in_tdata,
  // tuser: kind (0 write, 1 read)
  input  logic        in_tuser,
  // Answer channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: read_byte[7:0]
  output logic [7:0]  out_tdata,
  // tlast: last byte of the answer
  output logic        out_tlast,
  // Address register write port
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata
);

  // The controller sequences each request; the datapath holds every register,
  // the restoring divider for the scaled reads and the output register.
  sri_pkg::sri_cmd_t  cmd;
  sri_pkg::sri_stat_t stat;

  sri_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sri_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A write request never produces an answer byte.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == sri_pkg::KIND_WRITE) && !out_tvalid)
      |=> !out_tvalid)
    else $error("answer byte appeared after a write request");

  // The controller only loads the output register while it is busy with a read.
  a_no_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.load)
    else $error("output loaded while the controller was idle");

  // While the first byte of a two-byte answer waits, no new request is taken.
  a_pair_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("request taken before a two-byte answer was complete");

endmodule

// File: hdl/sri_ctrl.sv
// Controller state machine of the servo register interface.
module sri_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  input  sri_pkg::sri_stat_t stat,
  output sri_pkg::sri_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP0,
    S_PREP1,
    S_DIV,
    S_OUT0,
    S_OUT1
  } state_t;

  state_t                         state_r, state_nxt;
  sri_pkg::sri_ans_t              cls_r, cls_nxt;
  logic [sri_pkg::STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                           accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cls_nxt   = cls_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == sri_pkg::KIND_WRITE) begin
            cmd.write_en = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            cls_nxt     = stat.ans;
            case (stat.ans)
              sri_pkg::ANS_SCALE: state_nxt = S_PREP0;
              sri_pkg::ANS_BYTE,
              sri_pkg::ANS_PAIR:  state_nxt = S_OUT0;
              default:            state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_PREP0: begin
        cmd.prep_diff = 1'b1;
        state_nxt     = S_PREP1;
      end
      S_PREP1: begin
        cmd.prep_num = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == sri_pkg::STEP_W'(sri_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_OUT0;
        end
      end
      S_OUT0: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.last  = (cls_r != sri_pkg::ANS_PAIR);
          state_nxt = (cls_r == sri_pkg::ANS_PAIR) ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.hi_byte = 1'b1;
          cmd.last    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cls_r   <= sri_pkg::ANS_NONE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cls_r   <= cls_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: hdl/sri_dp.sv
// Datapath of the servo register interface: registers, scaling divider, output register.
module sri_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sri_pkg::sri_cmd_t                  cmd,
  output sri_pkg::sri_stat_t                 stat,
  input  logic [sri_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               cfg_wen,
  input  logic [sri_pkg::ADDR_W-1:0]         cfg_wdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sri_pkg::BYTE_W-1:0]         out_tdata,
  output logic                               out_tlast
);

  localparam int unsigned BW = sri_pkg::BYTE_W;
  localparam int unsigned WW = sri_pkg::WORD_W;
  localparam int unsigned NW = sri_pkg::NUM_W;

  // Fields of an incoming request
  logic [sri_pkg::CMD_W-1:0] f_command;
  logic [BW-1:0]             f_data_low, f_data_high, f_current;
  logic [WW-1:0]             f_position, f_drive;

  assign f_command   = in_tdata[7:0];
  assign f_data_low  = in_tdata[15:8];
  assign f_data_high = in_tdata[23:16];
  assign f_position  = in_tdata[39:24];
  assign f_current   = in_tdata[47:40];
  assign f_drive     = in_tdata[63:48];

  logic [sri_pkg::ADDR_W-1:0] addr_r;
  logic [sri_pkg::CMD_W-1:0]  stored_cmd_r;
  logic [WW-1:0]              target_r, lower_r, upper_r;
  logic [BW-1:0]              ceiling_r;
  logic [WW-1:0]              pos_r, drv_r;
  logic [BW-1:0]              cur_r;

  // Scaling divider
  logic signed [WW:0]         diff_r;
  logic [WW-1:0]              dmag_r;
  logic                       den_neg_r, den_zero_r, neg_r;
  logic [WW-1:0]              rem_r;
  logic [NW-1:0]              quo_r;

  logic [WW-1:0]              x_sel;
  logic signed [WW:0]         diff_nxt, den_nxt;
  logic signed [NW:0]         num;
  logic [WW:0]                shifted;
  logic [WW+1:0]              trial;
  logic                       ge;
  logic [BW-1:0]              scaled;

  logic                       out_valid_r, out_last_r;
  logic [BW-1:0]              out_byte_r;
  logic [BW-1:0]              ans_byte;
  logic [WW-1:0]              ans_word;

  // Answer shape of the stored command and room in the output register
  always_comb begin
    stat.out_free = !out_valid_r || out_tready;
    case (stored_cmd_r)
      sri_pkg::CMD_ADDR, sri_pkg::CMD_CURRENT, sri_pkg::CMD_CEILING:
        stat.ans = sri_pkg::ANS_BYTE;
      sri_pkg::CMD_POS_SCALED, sri_pkg::CMD_TGT_SCALED:
        stat.ans = sri_pkg::ANS_SCALE;
      sri_pkg::CMD_LOWER, sri_pkg::CMD_UPPER, sri_pkg::CMD_POSITION,
      sri_pkg::CMD_TARGET, sri_pkg::CMD_DRIVE:
        stat.ans = sri_pkg::ANS_PAIR;
      default:
        stat.ans = sri_pkg::ANS_NONE;
    endcase
  end

  // Register file and live-field capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= sri_pkg::ADDR_RESET;
      stored_cmd_r <= '0;
      target_r     <= '0;
      lower_r      <= '0;
      upper_r      <= sri_pkg::UPPER_RESET;
      ceiling_r    <= sri_pkg::CEILING_RESET;
    end else begin
      if (cfg_wen) begin
        addr_r <= cfg_wdata;
      end
      if (cmd.write_en) begin
        stored_cmd_r <= f_command;
        case (f_command)
          sri_pkg::CMD_TGT_SCALED,
          sri_pkg::CMD_TARGET:  target_r  <= {f_data_high, f_data_low};
          sri_pkg::CMD_CEILING: ceiling_r <= f_data_low;
          sri_pkg::CMD_LOWER:   lower_r   <= {f_data_high, f_data_low};
          sri_pkg::CMD_UPPER:   upper_r   <= {f_data_high, f_data_low};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r <= f_position;
      cur_r <= f_current;
      drv_r <= f_drive;
    end
  end

  // Scaling: (x - lower) * 255 / (upper - lower), signed, toward zero
  assign x_sel    = (stored_cmd_r == sri_pkg::CMD_POS_SCALED) ? pos_r : target_r;
  assign diff_nxt = $signed({x_sel[WW-1], x_sel}) - $signed({lower_r[WW-1], lower_r});
  assign den_nxt  = $signed({upper_r[WW-1], upper_r}) - $signed({lower_r[WW-1], lower_r});
  // times 255 as times 256 minus one
  assign num      = $signed({diff_r, 8'b0}) - $signed({{(NW-WW){diff_r[WW]}}, diff_r});

  assign shifted  = {rem_r, quo_r[NW-1]};
  assign trial    = {1'b0, shifted} - {2'b0, dmag_r};
  assign ge       = !trial[WW+1];
  assign scaled   = den_zero_r ? '0 : (neg_r ? BW'(-quo_r[BW-1:0]) : quo_r[BW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.prep_diff) begin
      diff_r     <= diff_nxt;
      den_neg_r  <= den_nxt[WW];
      den_zero_r <= (den_nxt == '0);
      dmag_r     <= den_nxt[WW] ? WW'(-den_nxt) : den_nxt[WW-1:0];
    end
    if (cmd.prep_num) begin
      rem_r <= '0;
      quo_r <= num[NW] ? NW'(-num) : num[NW-1:0];
      neg_r <= num[NW] ^ den_neg_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial[WW-1:0] : shifted[WW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  // Answer byte selection
  always_comb begin
    case (stored_cmd_r)
      sri_pkg::CMD_LOWER:    ans_word = lower_r;
      sri_pkg::CMD_UPPER:    ans_word = upper_r;
      sri_pkg::CMD_POSITION: ans_word = pos_r;
      sri_pkg::CMD_TARGET:   ans_word = target_r;
      default:               ans_word = drv_r;
    endcase
    case (stored_cmd_r)
      sri_pkg::CMD_ADDR:       ans_byte = {1'b0, addr_r};
      sri_pkg::CMD_POS_SCALED,
      sri_pkg::CMD_TGT_SCALED: ans_byte = scaled;
      sri_pkg::CMD_CURRENT:    ans_byte = cur_r;
      sri_pkg::CMD_CEILING:    ans_byte = ceiling_r;
      default:                 ans_byte = cmd.hi_byte ? ans_word[WW-1:BW] : ans_word[BW-1:0];
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= ans_byte;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule
